/* rtl/core/nat_pkg.sv */
// Package with constants, types and codes shared by the NAT table modules.
package nat_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [15:0] PortBaseReset = 16'd1024;
  localparam logic [7:0]  IdleTimeoutReset = 8'd50;

  typedef enum logic [1:0] {
    ActInsert  = 2'd0,
    ActLookIn  = 2'd1,
    ActLookOut = 2'd2,
    ActTick    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StHit  = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2,
    StTick = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegExtAddr  = 2'd0,
    RegPortBase = 2'd1,
    RegTimeout  = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmDone
  } fsm_e;

  typedef struct packed {
    logic [31:0] in_addr;
    logic [15:0] in_port;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic        kind;
    logic [7:0]  age;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/core/nat_mem.sv */
// Synchronous entry memory with one write and one registered read port.
module nat_mem import nat_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [TableEntries];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

/* rtl/core/nat_mapping_table_unit.sv */
// Top level of the NAT translation table: control, scan sequencer and registers.
// The result strobe comes after the scan of all TableEntries entries and the done state;
// busy falls with it, so a new item is accepted only once the last one is finished.
// The scan reads one entry a cycle from the synchronous memory, set by its port.
// Reset clears valid bits, counters and registers at once; no clearing pass.
// The result is shown for one cycle and the receiver cannot stall it.
module nat_mapping_table_unit import nat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] inside_address_i,
  input  logic [15:0] inside_port_i,
  input  logic [15:0] outside_port_i,
  input  logic        proto_kind_i,
  output logic        done,
  output logic [1:0]  status_o,
  output logic [31:0] found_inside_address_o,
  output logic [15:0] found_inside_port_o,
  output logic [31:0] found_outside_address_o,
  output logic [15:0] found_outside_port_o,
  output logic        found_kind_o,
  output logic [6:0]  expired_count_o
);

  fsm_e state_q, state_d;
  logic [31:0] ext_addr_q;
  logic [15:0] next_port_q;
  logic [7:0]  timeout_q;
  logic [31:0] ins_cnt_q;
  logic [TableEntries-1:0] valid_q;

  logic [1:0]  act_q;
  logic [31:0] k_addr_q;
  logic [15:0] k_inport_q, k_outport_q;
  logic        k_kind_q;

  logic [CntW-1:0] rd_cnt_q;
  logic            rvld_q;
  logic [IdxW-1:0] ridx_q;
  logic            best_vld_q;
  logic [IdxW-1:0] best_idx_q;
  entry_t          best_q;
  logic [6:0]      removed_q;

  mem_req_t req;
  entry_t   rdata;
  entry_t   aged;
  logic     match, better, expire, accept, free_any;
  logic [IdxW-1:0] free_idx;

  nat_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign accept = start && !busy;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    aged = rdata;
    if (rdata.age != 8'hFF) begin
      aged.age = rdata.age + 8'd1;
    end
    expire = valid_q[ridx_q] && (aged.age > timeout_q);
    if (act_q == ActLookIn) begin
      match = (rdata.in_addr == k_addr_q) && (rdata.in_port == k_inport_q);
    end else begin
      match = rdata.out_port == k_outport_q;
    end
    match = match && valid_q[ridx_q] && (rdata.kind == k_kind_q);
    better = match && (!best_vld_q || (rdata.stamp > best_q.stamp));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle: if (accept) state_d = FsmScan;
      FsmScan: if (rd_cnt_q == CntW'(TableEntries) && !rvld_q) state_d = FsmDone;
      FsmDone: state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    req.raddr = rd_cnt_q[IdxW-1:0];
    req.we = 1'b0;
    req.waddr = ridx_q;
    req.wdata = aged;
    if (state_q == FsmScan && rvld_q && act_q == ActTick && valid_q[ridx_q]) begin
      req.we = 1'b1;
    end
    if (state_q == FsmDone && act_q == ActInsert && free_any) begin
      req.we = 1'b1;
      req.waddr = free_idx;
      req.wdata.in_addr = k_addr_q;
      req.wdata.in_port = k_inport_q;
      req.wdata.out_addr = ext_addr_q;
      req.wdata.out_port = next_port_q;
      req.wdata.kind = k_kind_q;
      req.wdata.age = '0;
      req.wdata.stamp = ins_cnt_q;
    end
  end

  assign busy = state_q != FsmIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      ext_addr_q <= '0;
      next_port_q <= PortBaseReset;
      timeout_q <= IdleTimeoutReset;
      ins_cnt_q <= '0;
      valid_q <= '0;
      rd_cnt_q <= '0;
      rvld_q <= 1'b0;
      best_vld_q <= 1'b0;
      removed_q <= '0;
      done <= 1'b0;
    end else begin
      state_q <= state_d;
      done <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegExtAddr: ext_addr_q <= cfg_data_i;
          RegPortBase: begin
            next_port_q <= cfg_data_i[15:0];
          end
          RegTimeout: timeout_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        rd_cnt_q <= '0;
        rvld_q <= 1'b0;
        best_vld_q <= 1'b0;
        removed_q <= '0;
      end
      if (state_q == FsmScan) begin
        rvld_q <= rd_cnt_q != CntW'(TableEntries);
        if (rd_cnt_q != CntW'(TableEntries)) begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
        end
        if (rvld_q) begin
          if (act_q == ActTick) begin
            if (expire) begin
              valid_q[ridx_q] <= 1'b0;
              if (removed_q != 7'h7F) removed_q <= removed_q + 7'd1;
            end
          end else if (better) begin
            best_vld_q <= 1'b1;
          end
        end
      end
      if (state_q == FsmDone) begin
        done <= 1'b1;
        if (act_q == ActInsert && free_any) begin
          valid_q[free_idx] <= 1'b1;
          next_port_q <= next_port_q + 16'd1;
          ins_cnt_q <= ins_cnt_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= rd_cnt_q[IdxW-1:0];
    if (accept) begin
      act_q <= action_i;
      k_addr_q <= inside_address_i;
      k_inport_q <= inside_port_i;
      k_outport_q <= outside_port_i;
      k_kind_q <= proto_kind_i;
    end
    if (state_q == FsmScan && rvld_q && better) begin
      best_q <= rdata;
      best_idx_q <= ridx_q;
    end
    if (state_q == FsmDone) begin
      status_o <= StMiss;
      found_inside_address_o <= '0;
      found_inside_port_o <= '0;
      found_outside_address_o <= '0;
      found_outside_port_o <= '0;
      found_kind_o <= 1'b0;
      expired_count_o <= '0;
      case (act_q)
        ActInsert: begin
          if (free_any) begin
            status_o <= StHit;
            found_inside_address_o <= k_addr_q;
            found_inside_port_o <= k_inport_q;
            found_outside_address_o <= ext_addr_q;
            found_outside_port_o <= next_port_q;
            found_kind_o <= k_kind_q;
          end else begin
            status_o <= StFull;
          end
        end
        ActTick: begin
          status_o <= StTick;
          expired_count_o <= removed_q;
        end
        default: begin
          if (best_vld_q && valid_q[best_idx_q]) begin
            status_o <= StHit;
            found_inside_address_o <= best_q.in_addr;
            found_inside_port_o <= best_q.in_port;
            found_outside_address_o <= best_q.out_addr;
            found_outside_port_o <= best_q.out_port;
            found_kind_o <= best_q.kind;
          end
        end
      endcase
    end
  end

endmodule

/* tb/nat_mapping_table_unit_tb.sv */
// Self-checking testbench for the NAT mapping table: queued driver, predictor and monitor.
module nat_mapping_table_unit_tb;
  import nat_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 80;

  typedef struct {
    action_e     act;
    logic [31:0] ia;
    logic [15:0] ip;
    logic [15:0] op;
    logic        k;
  } item_t;

  typedef struct {
    status_e     st;
    logic [31:0] ia;
    logic [15:0] ip;
    logic [31:0] oa;
    logic [15:0] op;
    logic        k;
    logic [6:0]  cnt;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [31:0] inside_address_i = '0;
  logic [15:0] inside_port_i = '0;
  logic [15:0] outside_port_i = '0;
  logic        proto_kind_i = 1'b0;
  logic        done;
  logic [1:0]  status_o;
  logic [31:0] found_inside_address_o;
  logic [15:0] found_inside_port_o;
  logic [31:0] found_outside_address_o;
  logic [15:0] found_outside_port_o;
  logic        found_kind_o;
  logic [6:0]  expired_count_o;

  nat_mapping_table_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the table and registers.
  logic        tbl_valid [TableEntries];
  logic [31:0] tbl_ia    [TableEntries];
  logic [15:0] tbl_ip    [TableEntries];
  logic [31:0] tbl_oa    [TableEntries];
  logic [15:0] tbl_op    [TableEntries];
  logic        tbl_k     [TableEntries];
  logic [7:0]  tbl_age   [TableEntries];
  logic [31:0] tbl_stamp [TableEntries];
  logic [31:0] sh_ext_addr = 32'd0;
  logic [15:0] sh_next_port = PortBaseReset;
  logic [7:0]  sh_timeout = IdleTimeoutReset;
  logic [31:0] sh_inserts = 32'd0;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   cur_item;
  int      fail_count = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      cycles = 0;

  initial begin
    for (int i = 0; i < TableEntries; i++) tbl_valid[i] = 1'b0;
  end

  function automatic result_t nat_predict(item_t it);
    result_t r;
    int best;
    int removed;
    logic hit;
    r = '{st: StHit, ia: '0, ip: '0, oa: '0, op: '0, k: 1'b0, cnt: '0};
    best = -1;
    removed = 0;
    case (it.act)
      ActInsert: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (!tbl_valid[i] && best < 0) best = i;
        end
        if (best < 0) begin
          r.st = StFull;
        end else begin
          tbl_valid[best] = 1'b1;
          tbl_ia[best] = it.ia;
          tbl_ip[best] = it.ip;
          tbl_oa[best] = sh_ext_addr;
          tbl_op[best] = sh_next_port;
          tbl_k[best] = it.k;
          tbl_age[best] = 8'd0;
          tbl_stamp[best] = sh_inserts;
          sh_next_port = sh_next_port + 16'd1;
          sh_inserts = sh_inserts + 32'd1;
        end
      end
      ActLookIn, ActLookOut: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (tbl_valid[i] && tbl_k[i] == it.k) begin
            hit = (it.act == ActLookIn) ? (tbl_ia[i] == it.ia && tbl_ip[i] == it.ip)
                                        : (tbl_op[i] == it.op);
            if (hit && (best < 0 || tbl_stamp[i] > tbl_stamp[best])) best = i;
          end
        end
        if (best < 0) r.st = StMiss;
      end
      default: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_age[i] != 8'd255) tbl_age[i] = tbl_age[i] + 8'd1;
            if (tbl_age[i] > sh_timeout) begin
              tbl_valid[i] = 1'b0;
              if (removed < 127) removed++;
            end
          end
        end
        r.st = StTick;
        r.cnt = removed[6:0];
      end
    endcase
    if (r.st == StHit) begin
      r.ia = tbl_ia[best];
      r.ip = tbl_ip[best];
      r.oa = tbl_oa[best];
      r.op = tbl_op[best];
      r.k = tbl_k[best];
    end
    return r;
  endfunction

  // Driver: start stays high while items are queued back to back.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_results.push_back(nat_predict(cur_item));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          action_i <= cur_item.act;
          inside_address_i <= cur_item.ia;
          inside_port_i <= cur_item.ip;
          outside_port_i <= cur_item.op;
          proto_kind_i <= cur_item.k;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 120);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.st || found_inside_address_o !== e.ia ||
            found_inside_port_o !== e.ip || found_outside_address_o !== e.oa ||
            found_outside_port_o !== e.op || found_kind_o !== e.k ||
            expired_count_o !== e.cnt) begin
          $display("%0t: mismatch expected st=%0d ia=%h ip=%h oa=%h op=%h k=%b cnt=%0d",
                   $time, e.st, e.ia, e.ip, e.oa, e.op, e.k, e.cnt);
          $display("%0t:          actual st=%0d ia=%h ip=%h oa=%h op=%h k=%b cnt=%0d",
                   $time, status_o, found_inside_address_o, found_inside_port_o,
                   found_outside_address_o, found_outside_port_o, found_kind_o,
                   expired_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegExtAddr:  sh_ext_addr = val;
      RegPortBase: sh_next_port = val[15:0];
      default:     sh_timeout = val[7:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic item_t mk(action_e a, logic [31:0] ia, logic [15:0] ip,
                               logic [15:0] op, logic k);
    item_t it;
    it = '{act: a, ia: ia, ip: ip, op: op, k: k};
    return it;
  endfunction

  function automatic item_t rand_item(int insert_pct);
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) it.act = ActInsert;
    else if (r < insert_pct + (100 - insert_pct) * 3 / 8) it.act = ActLookIn;
    else if (r < insert_pct + (100 - insert_pct) * 6 / 8) it.act = ActLookOut;
    else it.act = ActTick;
    it.ia = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0a00_0000 + $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) it.ia = ($urandom_range(0, 1) != 0) ? '1 : '0;
    it.ip = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    it.op = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'(sh_next_port - $urandom_range(0, 70));
    it.k = 1'($urandom);
    return it;
  endfunction

  initial begin
    logic [31:0] ext_vals [5];
    logic [31:0] base_vals [5];
    logic [31:0] tmo_vals [5];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset register values.
    pending_items.push_back(mk(ActLookIn, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActTick, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActInsert, 32'h0, 16'h0, 16'hffff, 1'b0));
    pending_items.push_back(mk(ActInsert, 32'hffff_ffff, 16'hffff, 16'h0, 1'b1));
    pending_items.push_back(mk(ActInsert, 32'hffff_ffff, 16'hffff, 16'h0, 1'b1));
    pending_items.push_back(mk(ActInsert, 32'hffff_ffff, 16'hffff, 16'h0, 1'b0));
    pending_items.push_back(mk(ActLookIn, 32'hffff_ffff, 16'hffff, 16'h0, 1'b1));
    pending_items.push_back(mk(ActLookIn, 32'hffff_ffff, 16'hffff, 16'h0, 1'b0));
    pending_items.push_back(mk(ActLookIn, 32'h0, 16'h0, 16'h0, 1'b1));
    pending_items.push_back(mk(ActLookIn, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActLookOut, 32'h0, 16'h0, 16'd1024, 1'b0));
    pending_items.push_back(mk(ActLookOut, 32'h0, 16'h0, 16'd1024, 1'b1));
    pending_items.push_back(mk(ActLookOut, 32'h0, 16'h0, 16'd1026, 1'b1));
    pending_items.push_back(mk(ActLookOut, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b1));
    pending_items.push_back(mk(ActTick, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b1));
    wait_idle();

    write_reg(RegTimeout, 32'hffff_ff01);
    pending_items.push_back(mk(ActTick, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActInsert, 32'h1234_5678, 16'h55aa, 16'h0, 1'b1));
    pending_items.push_back(mk(ActTick, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActTick, 32'h0, 16'h0, 16'h0, 1'b0));
    pending_items.push_back(mk(ActLookIn, 32'h1234_5678, 16'h55aa, 16'h0, 1'b1));
    wait_idle();

    ext_vals = '{32'h0, 32'hffff_ffff, $urandom, $urandom, 32'hc0a8_0001};
    base_vals = '{32'h0, 32'hffff_ffc0, $urandom, 32'h0000_ffff, $urandom};
    tmo_vals = '{32'h0000_00ff, 32'h2, 32'd1 + $urandom_range(0, 254), 32'd5, 32'hff};

    for (int p = 0; p < 10; p++) begin
      write_reg(RegExtAddr, ext_vals[p % 5]);
      write_reg(RegPortBase, base_vals[(p + 2) % 5]);
      write_reg(RegTimeout, tmo_vals[p % 5] | ($urandom & 32'hffff_ff00));
      if (p == 0 || p == 5) begin
        // Fill the table past its size, then probe it and tick its ages.
        repeat (70) pending_items.push_back(rand_item(100));
        repeat (30) pending_items.push_back(rand_item(0));
      end else begin
        repeat (55) pending_items.push_back(rand_item(45));
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
